### rtl/core/hdrts_pkg.sv
// ---------------------------------------------------------------------------
// hdrts_pkg
// Types, codes and reset values shared by the radio turn scheduler files
// ---------------------------------------------------------------------------
package hdrts_pkg;

    typedef enum logic [2:0] {
        MODE_INIT  = 3'd0,
        MODE_RX    = 3'd1,
        MODE_TX    = 3'd2,
        MODE_GO_RX = 3'd3,
        MODE_GO_TX = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        CMD_NONE     = 2'd0,
        CMD_START_RX = 2'd1,
        CMD_STOP_RX  = 2'd2,
        CMD_REINIT   = 2'd3
    } cmd_t;

    // radio event codes
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_MESSAGE = 3'd1;

    // transmit outcome codes
    localparam logic [1:0] TX_FAIL = 2'd0;
    localparam logic [1:0] TX_OK   = 2'd1;

    // register indexes (word address)
    localparam logic [1:0] REG_MIN_LISTEN = 2'd0;
    localparam logic [1:0] REG_MAX_TX     = 2'd1;
    localparam logic [1:0] REG_MIN_GAP    = 2'd2;

    localparam int unsigned ADDR_W = 4;

    localparam logic [15:0] MIN_LISTEN_RST = 16'd100;
    localparam logic [15:0] MAX_TX_RST     = 16'd1000;
    localparam logic [15:0] MIN_GAP_RST    = 16'd100;

    typedef struct packed {
        logic [15:0] min_listen_ms;
        logic [15:0] max_tx_ms;
        logic [15:0] min_gap_ms;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [2:0]  radio_event;
        logic        rx_intact;
        logic        reply_wanted;
        logic        tx_available;
        logic [31:0] last_sent_ms;
        logic [1:0]  tx_outcome;
        logic        tx_wants_ack;
        logic [15:0] random_extra;
    } item_t;

    typedef struct packed {
        mode_t       mode;
        logic        listening;
        logic [31:0] last_rx_time;
        logic [15:0] extra_listen;
    } state_t;

    typedef struct packed {
        mode_t mode_now;
        cmd_t  radio_cmd;
        logic  deliver_rx;
        logic  start_tx;
        logic  mark_sent;
    } result_t;

endpackage

### rtl/core/hdrts_cfg.sv
// ---------------------------------------------------------------------------
// hdrts_cfg
// APB-style register file holding the three timing registers
// ---------------------------------------------------------------------------
module hdrts_cfg
    import hdrts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t        cfg_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_listen_ms <= MIN_LISTEN_RST;
            cfg_reg.max_tx_ms     <= MAX_TX_RST;
            cfg_reg.min_gap_ms    <= MIN_GAP_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MIN_LISTEN: cfg_reg.min_listen_ms <= pwdata[15:0];
                REG_MAX_TX:     cfg_reg.max_tx_ms     <= pwdata[15:0];
                REG_MIN_GAP:    cfg_reg.min_gap_ms    <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MIN_LISTEN: prdata = {16'd0, cfg_reg.min_listen_ms};
            REG_MAX_TX:     prdata = {16'd0, cfg_reg.max_tx_ms};
            REG_MIN_GAP:    prdata = {16'd0, cfg_reg.min_gap_ms};
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/hdrts_step.sv
// ---------------------------------------------------------------------------
// hdrts_step
// Next-state and result logic for one scheduler step
// ---------------------------------------------------------------------------
module hdrts_step
    import hdrts_pkg::*;
(
    input  cfg_t    cfg,
    input  item_t   item,
    input  state_t  st,
    output state_t  st_next,
    output result_t res
);

    logic [31:0] since_sent;
    logic [31:0] rx_age;
    logic [17:0] rx_window;
    logic [16:0] tx_limit;
    logic        rx_timeout;
    logic        gap_ok;
    logic        listen_ok;

    assign since_sent = item.now_ms - item.last_sent_ms;
    assign rx_age     = item.now_ms - st.last_rx_time;
    // extra + 2*min_listen + gap
    assign rx_window  = {2'd0, st.extra_listen} + {1'b0, cfg.min_listen_ms, 1'b0}
                      + {2'd0, cfg.min_gap_ms};
    assign tx_limit   = {1'b0, cfg.min_listen_ms} + {1'b0, cfg.max_tx_ms};
    // a received message restarts the window, so no timeout in that step
    assign rx_timeout = (item.radio_event != EV_MESSAGE)
                      && (rx_age > {14'd0, rx_window});
    assign gap_ok     = since_sent > {16'd0, cfg.min_gap_ms};
    assign listen_ok  = since_sent > {16'd0, cfg.min_listen_ms};

    always_comb
    begin
        st_next        = st;
        res.radio_cmd  = CMD_NONE;
        res.deliver_rx = 1'b0;
        res.start_tx   = 1'b0;
        res.mark_sent  = 1'b0;

        case (st.mode)
            MODE_RX:
            begin
                if (item.radio_event == EV_MESSAGE)
                begin
                    res.radio_cmd   = CMD_START_RX;
                    st_next.last_rx_time = item.now_ms;
                    if (item.rx_intact)
                    begin
                        res.deliver_rx = 1'b1;
                        if (item.reply_wanted)
                            st_next.mode = MODE_GO_TX;
                    end
                end
                else if (item.radio_event != EV_NONE)
                    res.radio_cmd = CMD_START_RX;
                if (rx_timeout)
                begin
                    st_next.mode         = MODE_GO_TX;
                    st_next.last_rx_time = item.now_ms;
                end
            end
            MODE_TX:
            begin
                st_next.mode = MODE_GO_TX;
                if (item.tx_available)
                begin
                    res.start_tx = 1'b1;
                    if (item.tx_outcome == TX_FAIL)
                        res.radio_cmd = CMD_REINIT;
                    else if (item.tx_outcome == TX_OK)
                    begin
                        res.mark_sent = 1'b1;
                        if (item.tx_wants_ack)
                            st_next.mode = MODE_GO_RX;
                    end
                end
            end
            MODE_GO_RX:
            begin
                if (!st.listening)
                begin
                    st_next.listening = 1'b1;
                    res.radio_cmd     = CMD_START_RX;
                end
                st_next.last_rx_time = item.now_ms;
                if (cfg.min_listen_ms == 16'd0)
                    st_next.extra_listen = 16'd0;
                else if (item.random_extra >= cfg.min_listen_ms)
                    st_next.extra_listen = cfg.min_listen_ms - 16'd1;
                else
                    st_next.extra_listen = item.random_extra;
                st_next.mode = MODE_RX;
            end
            MODE_GO_TX:
            begin
                if (rx_age > {15'd0, tx_limit})
                begin
                    if (listen_ok)
                        st_next.mode = MODE_GO_RX;
                end
                else if (item.tx_available)
                begin
                    if (st.listening)
                    begin
                        st_next.listening = 1'b0;
                        res.radio_cmd     = CMD_STOP_RX;
                    end
                    if (gap_ok)
                        st_next.mode = MODE_TX;
                end
                else if (listen_ok)
                    st_next.mode = MODE_GO_RX;
            end
            default:
                st_next.mode = MODE_GO_RX;
        endcase

        res.mode_now = st_next.mode;
    end

endmodule

### rtl/core/half_duplex_radio_turn_scheduler_unit.sv
// ---------------------------------------------------------------------------
// half_duplex_radio_turn_scheduler_unit
// Five-mode scheduler that alternates one radio between listening and sending
// ---------------------------------------------------------------------------
// request accept to result valid: input reg, then result reg
// throughput: one request per cycle unless out_ready stalls; the step logic
//   between the two registers is a single pass of 32-bit subtract/compare logic
// reset: rst_n clears mode to init, listening, last rx time and extra listen
//   time, loads the timing registers with 100 / 1000 / 100 ms, empties both regs
module half_duplex_radio_turn_scheduler_unit
    import hdrts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // config port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // request channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [31:0]       now_ms,
    input  logic [2:0]        radio_event,
    input  logic              rx_intact,
    input  logic              reply_wanted,
    input  logic              tx_available,
    input  logic [31:0]       last_sent_ms,
    input  logic [1:0]        tx_outcome,
    input  logic              tx_wants_ack,
    input  logic [15:0]       random_extra,
    // result channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        mode_now,
    output logic [1:0]        radio_cmd,
    output logic              deliver_rx,
    output logic              start_tx,
    output logic              mark_sent
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    result_t res_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    in_fire;

    hdrts_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // a held request steps the scheduler once the result reg is free or draining
    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    // input reg refills in the same cycle it hands its request on
    assign in_ready = !item_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    // request register: payload only loads, valid flag is reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.now_ms       <= now_ms;
            item_reg.radio_event  <= radio_event;
            item_reg.rx_intact    <= rx_intact;
            item_reg.reply_wanted <= reply_wanted;
            item_reg.tx_available <= tx_available;
            item_reg.last_sent_ms <= last_sent_ms;
            item_reg.tx_outcome   <= tx_outcome;
            item_reg.tx_wants_ack <= tx_wants_ack;
            item_reg.random_extra <= random_extra;
        end
    end

    hdrts_step u_step (
        .cfg     (cfg),
        .item    (item_reg),
        .st      (state_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    // scheduler state moves only when a request is stepped, so the next
    // request in the input reg sees the updated state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode         <= MODE_INIT;
            state_reg.listening    <= 1'b0;
            state_reg.last_rx_time <= 32'd0;
            state_reg.extra_listen <= 16'd0;
        end
        else if (advance)
            state_reg <= state_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid  = out_valid_reg;
    assign mode_now   = res_reg.mode_now;
    assign radio_cmd  = res_reg.radio_cmd;
    assign deliver_rx = res_reg.deliver_rx;
    assign start_tx   = res_reg.start_tx;
    assign mark_sent  = res_reg.mark_sent;

endmodule

### rtl/core/hdrts_checker.sv
// ---------------------------------------------------------------------------
// hdrts_checker
// Port-level checks on the scheduler result channel
// ---------------------------------------------------------------------------
module hdrts_checker
    import hdrts_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] mode_now,
    input logic [1:0] radio_cmd,
    input logic       deliver_rx,
    input logic       start_tx,
    input logic       mark_sent
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mode_now)
            && $stable(radio_cmd) && $stable(start_tx))
        else $error("result changed while stalled");

    // a step never leaves the scheduler in init or an unused mode
    a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> mode_now != MODE_INIT && mode_now != 3'd5
            && mode_now != 3'd6 && mode_now != 3'd7)
        else $error("illegal mode after step");

    // a send always leaves for go-to-transmit or go-to-receive
    a_send_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && start_tx |-> (mode_now == MODE_GO_TX || mode_now == MODE_GO_RX)
            && (radio_cmd == CMD_NONE || radio_cmd == CMD_REINIT))
        else $error("bad mode or command after send");

    // mark only after a successful send
    a_mark_send: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mark_sent |-> start_tx && radio_cmd == CMD_NONE)
        else $error("mark without successful send");

    // delivery comes with a receive restart
    a_deliver_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && deliver_rx |-> radio_cmd == CMD_START_RX && !start_tx)
        else $error("delivery without receive restart");

endmodule

bind half_duplex_radio_turn_scheduler_unit hdrts_checker u_hdrts_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mode_now   (mode_now),
    .radio_cmd  (radio_cmd),
    .deliver_rx (deliver_rx),
    .start_tx   (start_tx),
    .mark_sent  (mark_sent)
);

### tb/half_duplex_radio_turn_scheduler_unit_test.sv
// ---------------------------------------------------------------------------
// half_duplex_radio_turn_scheduler_unit_test
// Drives step requests through the turn scheduler and checks every result
// against a directed expectation or an in-bench model of the five-mode turn
// logic, under several timing register settings and random stalls on both channels
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module half_duplex_radio_turn_scheduler_unit_test;
    import hdrts_pkg::*;

    // radio event and transmit outcome codes the package does not name
    localparam logic [2:0] EV_TIMEOUT = 3'd2;
    localparam logic [2:0] EV_UNKNOWN = 3'd3;
    localparam logic [2:0] EV_OTHER   = 3'd4;
    localparam logic [2:0] EV_SPARE   = 3'd7;
    localparam logic [1:0] TX_OTHER   = 2'd2;
    localparam logic [1:0] TX_SPARE   = 2'd3;

    localparam int unsigned RANDOM_ITEMS    = 1750;
    localparam int unsigned PHASE_LEN       = 292;
    localparam int unsigned CALM_ITEMS      = 150;
    localparam int unsigned HOLD_OFF_CYCLES = 200;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned NUM_ROWS        = 27;
    localparam int unsigned NUM_PLANS       = 5;

    // one row of the directed stimulus; the expected result is only filled
    // in where known is set, other rows go through the model
    typedef struct {
        logic [31:0] now;
        logic [2:0]  ev;
        logic        intact;
        logic        reply;
        logic        avail;
        logic [31:0] sent;
        logic [1:0]  outcome;
        logic        ack;
        logic [15:0] rnd;
        logic        known;
        mode_t       want_mode;
        cmd_t        want_cmd;
        logic [2:0]  want_flags;   // deliver_rx, start_tx, mark_sent
    } dir_row_t;

    typedef struct {
        logic [15:0] listen;
        logic [15:0] max_tx;
        logic [15:0] gap;
    } timing_t;

    // ------------------------------------------------------------------
    // block signals; all bench-driven inputs are known from time zero
    // ------------------------------------------------------------------
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    wire  [31:0]       prdata;
    wire               pready;
    logic              in_valid = 1'b0;
    wire               in_ready;
    logic [31:0]       now_ms = '0;
    logic [2:0]        radio_event = '0;
    logic              rx_intact = 1'b0;
    logic              reply_wanted = 1'b0;
    logic              tx_available = 1'b0;
    logic [31:0]       last_sent_ms = '0;
    logic [1:0]        tx_outcome = '0;
    logic              tx_wants_ack = 1'b0;
    logic [15:0]       random_extra = '0;
    wire               out_valid;
    logic              out_ready = 1'b0;
    wire  [2:0]        mode_now;
    wire  [1:0]        radio_cmd;
    wire               deliver_rx;
    wire               start_tx;
    wire               mark_sent;

    half_duplex_radio_turn_scheduler_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .now_ms       (now_ms),
        .radio_event  (radio_event),
        .rx_intact    (rx_intact),
        .reply_wanted (reply_wanted),
        .tx_available (tx_available),
        .last_sent_ms (last_sent_ms),
        .tx_outcome   (tx_outcome),
        .tx_wants_ack (tx_wants_ack),
        .random_extra (random_extra),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mode_now     (mode_now),
        .radio_cmd    (radio_cmd),
        .deliver_rx   (deliver_rx),
        .start_tx     (start_tx),
        .mark_sent    (mark_sent)
    );

    // ------------------------------------------------------------------
    // model of the scheduler: timing registers and turn state
    // ------------------------------------------------------------------
    logic [15:0] cfg_min_listen = MIN_LISTEN_RST;
    logic [15:0] cfg_max_tx     = MAX_TX_RST;
    logic [15:0] cfg_min_gap    = MIN_GAP_RST;

    mode_t       turn_mode       = MODE_INIT;
    logic        turn_listening  = 1'b0;
    logic [31:0] turn_last_rx_ms = '0;
    logic [15:0] turn_extra_ms   = '0;

    // results still owed by the block, oldest first
    result_t     pending_turns[$];

    // known result for the request on the port, set along with the payload
    logic        known_valid = 1'b0;
    result_t     known_result = '0;

    // run bookkeeping
    int unsigned mismatches = 0;
    int unsigned results_checked = 0;
    int unsigned requests_sent = 0;
    int unsigned cycle_count = 0;
    logic [31:0] sim_clock_ms = '0;
    logic        hold_off_req = 1'b0;
    logic        calm = 1'b0;

    // directed rows: reset, clamp, every mode path, event codes above
    // the named range, time wrap and the silence window boundary
    dir_row_t stim_rows [NUM_ROWS] = '{
        // leaving init after reset goes straight to go-to-receive
        '{32'd500, EV_NONE, 1'b0, 1'b0, 1'b0, 32'd0, TX_FAIL, 1'b0, 16'd0,
          1'b1, MODE_GO_RX, CMD_NONE, 3'b000},
        // random value at its top, clamped below min listen; radio starts
        '{32'd1000, EV_NONE, 1'b0, 1'b0, 1'b0, 32'd0, TX_FAIL, 1'b0, 16'hffff,
          1'b1, MODE_RX, CMD_START_RX, 3'b000},
        // intact message with a reply wanted
        '{32'd1010, EV_MESSAGE, 1'b1, 1'b1, 1'b0, 32'd0, TX_FAIL, 1'b0, 16'd0,
          1'b0, MODE_INIT, CMD_NONE, 3'b000},
        // packet waiting while listening: stop receive, go transmit
        '{32'd1020, EV_NONE, 1'b0, 1'b0, 1'b1, 32'd0, TX_FAIL, 1'b0, 16'd0,
          1'b0, MODE_INIT, CMD_NONE, 3'b000},
        // failed send asks for a radio reinit
        '{32'd1025, EV_NONE, 1'b0, 1'b0, 1'b1, 32'd0, TX_FAIL, 1'b0, 16'd0,
          1'b1, MODE_GO_TX, CMD_REINIT, 3'b010},
        '{32'd1030, EV_NONE, 1'b0, 1'b0, 1'b1, 32'd0, TX_FAIL, 1'b0, 16'd0,
          1'b0, MODE_INIT, CMD_NONE, 3'b000},
        // success with ack wanted turns around to receive
        '{32'd1035, EV_NONE, 1'b0, 1'b0, 1'b1, 32'd0, TX_OK, 1'b1, 16'd0,
          1'b0, MODE_INIT, CMD_NONE, 3'b000},
        '{32'd1040, EV_NONE, 1'b0, 1'b0, 1'b0, 32'd0, TX_FAIL, 1'b0, 16'd5,
          1'b0, MODE_INIT, CMD_NONE, 3'b000},
        // event code past "other" restarts passive receive
        '{32'd1050, EV_SPARE, 1'b1, 1'b1, 1'b1, 32'hffffffff, TX_SPARE, 1'b1,
          16'd0, 1'b0, MODE_INIT, CMD_NONE, 3'b000},
        // silence window just exceeded
        '{32'd1346, EV_NONE, 1'b0, 1'b0, 1'b0, 32'd0, TX_FAIL, 1'b0, 16'd0,
          1'b0, MODE_INIT, CMD_NONE, 3'b000},
        // packet waiting but the gap since the last send is too short
        '{32'd1360, EV_NONE, 1'b0, 1'b0, 1'b1, 32'd1300, TX_FAIL, 1'b0, 16'd0,
          1'b0, MODE_INIT, CMD_NONE, 3'b000},
        '{32'd1401, EV_NONE, 1'b0, 1'b0, 1'b0, 32'd1300, TX_FAIL, 1'b0, 16'd0,
          1'b0, MODE_INIT, CMD_NONE, 3'b000},
        '{32'd1410, EV_NONE, 1'b0, 1'b0, 1'b0, 32'd0, TX_FAIL, 1'b0, 16'd99,
          1'b0, MODE_INIT, CMD_NONE, 3'b000},
        // message that failed its integrity check
        '{32'd1420, EV_MESSAGE, 1'b0, 1'b1, 1'b0, 32'd0, TX_FAIL, 1'b0, 16'd0,
          1'b0, MODE_INIT, CMD_NONE, 3'b000},
        '{32'd1430, EV_MESSAGE, 1'b1, 1'b0, 1'b0, 32'd0, TX_FAIL, 1'b0, 16'd0,
          1'b0, MODE_INIT, CMD_NONE, 3'b000},
        // time at its top with an unknown message
        '{32'hffffffff, EV_UNKNOWN, 1'b0, 1'b0, 1'b0, 32'd0, TX_FAIL, 1'b0,
          16'd0, 1'b0, MODE_INIT, CMD_NONE, 3'b000},
        // time wrapped past zero
        '{32'h10, EV_OTHER, 1'b0, 1'b0, 1'b1, 32'hfffffff0, TX_FAIL, 1'b0,
          16'd0, 1'b0, MODE_INIT, CMD_NONE, 3'b000},
        '{32'h100, EV_TIMEOUT, 1'b0, 1'b0, 1'b1, 32'hfffffff0, TX_FAIL, 1'b0,
          16'd0, 1'b0, MODE_INIT, CMD_NONE, 3'b000},
        // transmit with nothing to send
        '{32'h108, EV_NONE, 1'b0, 1'b0, 1'b0, 32'd0, TX_OK, 1'b1, 16'd0,
          1'b0, MODE_INIT, CMD_NONE, 3'b000},
        // go-to-transmit past min listen plus max tx
        '{32'h1000, EV_NONE, 1'b0, 1'b0, 1'b0, 32'd0, TX_FAIL, 1'b0, 16'd0,
          1'b0, MODE_INIT, CMD_NONE, 3'b000},
        '{32'h2000, EV_NONE, 1'b0, 1'b0, 1'b0, 32'd0, TX_FAIL, 1'b0, 16'd0,
          1'b0, MODE_INIT, CMD_NONE, 3'b000},
        // exactly at the silence window, then one past it
        '{32'h2000 + 32'd300, EV_NONE, 1'b0, 1'b0, 1'b0, 32'd0, TX_FAIL, 1'b0,
          16'd0, 1'b0, MODE_INIT, CMD_NONE, 3'b000},
        '{32'h2000 + 32'd301, EV_NONE, 1'b0, 1'b0, 1'b0, 32'd0, TX_FAIL, 1'b0,
          16'd0, 1'b0, MODE_INIT, CMD_NONE, 3'b000},
        '{32'h2200, EV_NONE, 1'b0, 1'b0, 1'b1, 32'd0, TX_FAIL, 1'b0, 16'd0,
          1'b0, MODE_INIT, CMD_NONE, 3'b000},
        // outcome "other": sent, but no command and no mark
        '{32'h2210, EV_NONE, 1'b0, 1'b0, 1'b1, 32'd0, TX_OTHER, 1'b1, 16'd0,
          1'b0, MODE_INIT, CMD_NONE, 3'b000},
        '{32'h2220, EV_NONE, 1'b0, 1'b0, 1'b1, 32'd0, TX_FAIL, 1'b0, 16'd0,
          1'b0, MODE_INIT, CMD_NONE, 3'b000},
        // unused outcome code behaves like "other"
        '{32'h2230, EV_NONE, 1'b0, 1'b0, 1'b1, 32'd0, TX_SPARE, 1'b1, 16'd0,
          1'b0, MODE_INIT, CMD_NONE, 3'b000}
    };

    // timing settings of the random phases; the first phase runs on the
    // reset values, min listen zero pins the extra listen time at zero
    timing_t plans [NUM_PLANS] = '{
        '{16'd1, 16'd0, 16'd0},
        '{16'hffff, 16'hffff, 16'hffff},
        '{16'd0, 16'd500, 16'd50},
        '{16'd20, 16'd100, 16'd30},
        '{MIN_LISTEN_RST, MAX_TX_RST, MIN_GAP_RST}
    };

    // ------------------------------------------------------------------
    // clock, reset and run limit
    // ------------------------------------------------------------------
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("run limit of %0d cycles hit, %0d results still pending",
                     CYCLE_LIMIT, pending_turns.size());
            $display("half_duplex_radio_turn_scheduler_unit_test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // one scheduler step of the model: updates the turn state and returns
    // the result the block owes for this request
    // ------------------------------------------------------------------
    function automatic result_t advance_turn(input item_t req);
        result_t     res;
        logic [31:0] since_sent;
        logic [31:0] window;

        res            = '0;
        res.radio_cmd  = CMD_NONE;
        since_sent     = req.now_ms - req.last_sent_ms;
        case (turn_mode)
            MODE_RX:
            begin
                if (req.radio_event == EV_MESSAGE)
                begin
                    res.radio_cmd   = CMD_START_RX;
                    turn_last_rx_ms = req.now_ms;
                    if (req.rx_intact)
                    begin
                        res.deliver_rx = 1'b1;
                        if (req.reply_wanted)
                            turn_mode = MODE_GO_TX;
                    end
                end
                else if (req.radio_event != EV_NONE)
                    res.radio_cmd = CMD_START_RX;
                // silence window: extra listen + two min listens + min gap
                window = 32'(turn_extra_ms) + 32'(cfg_min_listen) * 2
                         + 32'(cfg_min_gap);
                if (req.now_ms - turn_last_rx_ms > window)
                begin
                    turn_mode       = MODE_GO_TX;
                    turn_last_rx_ms = req.now_ms;
                end
            end
            MODE_TX:
            begin
                turn_mode = MODE_GO_TX;
                if (req.tx_available)
                begin
                    res.start_tx = 1'b1;
                    if (req.tx_outcome == TX_FAIL)
                        res.radio_cmd = CMD_REINIT;
                    else if (req.tx_outcome == TX_OK)
                    begin
                        res.mark_sent = 1'b1;
                        if (req.tx_wants_ack)
                            turn_mode = MODE_GO_RX;
                    end
                end
            end
            MODE_GO_RX:
            begin
                if (!turn_listening)
                begin
                    turn_listening = 1'b1;
                    res.radio_cmd  = CMD_START_RX;
                end
                turn_last_rx_ms = req.now_ms;
                if (cfg_min_listen == 16'd0)
                    turn_extra_ms = '0;
                else if (req.random_extra >= cfg_min_listen)
                    turn_extra_ms = cfg_min_listen - 16'd1;
                else
                    turn_extra_ms = req.random_extra;
                turn_mode = MODE_RX;
            end
            MODE_GO_TX:
            begin
                if (req.now_ms - turn_last_rx_ms
                    > 32'(cfg_min_listen) + 32'(cfg_max_tx))
                begin
                    if (since_sent > 32'(cfg_min_listen))
                        turn_mode = MODE_GO_RX;
                end
                else if (req.tx_available)
                begin
                    if (turn_listening)
                    begin
                        turn_listening = 1'b0;
                        res.radio_cmd  = CMD_STOP_RX;
                    end
                    if (since_sent > 32'(cfg_min_gap))
                        turn_mode = MODE_TX;
                end
                else if (since_sent > 32'(cfg_min_listen))
                    turn_mode = MODE_GO_RX;
            end
            default:
                turn_mode = MODE_GO_RX;
        endcase
        res.mode_now = turn_mode;
        return res;
    endfunction

    function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %0d at %0t: %s expected %0h got %0h",
                     mismatches, $time, what, want, got);
    endfunction

    // ------------------------------------------------------------------
    // scoreboard: check results, then predict for the request taken at
    // this edge; all values read here are the ones from before the edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        result_t predicted;
        item_t   req;

        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (pending_turns.size() == 0)
                    flag_mismatch("result with nothing pending, mode_now", '0,
                                  32'(mode_now));
                else
                begin
                    want = pending_turns.pop_front();
                    if (mode_now !== want.mode_now)
                        flag_mismatch("mode_now", 32'(want.mode_now), 32'(mode_now));
                    if (radio_cmd !== want.radio_cmd)
                        flag_mismatch("radio_cmd", 32'(want.radio_cmd), 32'(radio_cmd));
                    if (deliver_rx !== want.deliver_rx)
                        flag_mismatch("deliver_rx", 32'(want.deliver_rx),
                                      32'(deliver_rx));
                    if (start_tx !== want.start_tx)
                        flag_mismatch("start_tx", 32'(want.start_tx), 32'(start_tx));
                    if (mark_sent !== want.mark_sent)
                        flag_mismatch("mark_sent", 32'(want.mark_sent), 32'(mark_sent));
                end
            end

            if (in_valid && in_ready)
            begin
                req.now_ms       = now_ms;
                req.radio_event  = radio_event;
                req.rx_intact    = rx_intact;
                req.reply_wanted = reply_wanted;
                req.tx_available = tx_available;
                req.last_sent_ms = last_sent_ms;
                req.tx_outcome   = tx_outcome;
                req.tx_wants_ack = tx_wants_ack;
                req.random_extra = random_extra;
                // the model always runs so its state keeps up
                predicted = advance_turn(req);
                if (known_valid)
                    pending_turns.push_back(known_result);
                else
                    pending_turns.push_back(predicted);
                requests_sent++;
            end
        end
    end

    // ------------------------------------------------------------------
    // result side back-pressure: random stall bursts, one long hold-off
    // on request, always ready once the run calms down
    // ------------------------------------------------------------------
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // request side helpers; each is entered right after a rising edge
    // ------------------------------------------------------------------

    // put one request on the port and hold it until it is taken
    task automatic offer_request(input item_t req, input logic known,
                                 input result_t known_res);
        in_valid     <= 1'b1;
        now_ms       <= req.now_ms;
        radio_event  <= req.radio_event;
        rx_intact    <= req.rx_intact;
        reply_wanted <= req.reply_wanted;
        tx_available <= req.tx_available;
        last_sent_ms <= req.last_sent_ms;
        tx_outcome   <= req.tx_outcome;
        tx_wants_ack <= req.tx_wants_ack;
        random_extra <= req.random_extra;
        known_valid  <= known;
        known_result <= known_res;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // random idle burst on the request side
    task automatic maybe_pause();
        if (!calm && !hold_off_req && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // stop offering and let every owed result come out, plus the latency
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_turns.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // register write: setup cycle, then access cycle until pready
    task automatic write_setting(input logic [1:0] index, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_MIN_LISTEN: cfg_min_listen = value;
            REG_MAX_TX:     cfg_max_tx = value;
            REG_MIN_GAP:    cfg_min_gap = value;
            default:        ;
        endcase
        @(posedge clk);
    endtask

    // random step: time mostly creeps forward at a pace set by the timing
    // registers so windows and gaps are crossed often, with rare jumps
    function automatic item_t make_random_request();
        item_t       req;
        logic [31:0] span;
        int unsigned pick;

        span = 32'(cfg_min_listen) / 2 + 32'(cfg_min_gap) / 2 + 8;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            sim_clock_ms = $urandom();
        else if (pick == 1)
            sim_clock_ms = sim_clock_ms + 32'(cfg_max_tx) + $urandom_range(0, span);
        else
            sim_clock_ms = sim_clock_ms + $urandom_range(0, span);
        req.now_ms = sim_clock_ms;

        if ($urandom_range(0, 15) == 0)
            req.last_sent_ms = $urandom();
        else
            req.last_sent_ms = sim_clock_ms - $urandom_range(0, 2 * span);

        pick = $urandom_range(0, 15);
        if (pick < 7)
            req.radio_event = EV_NONE;
        else if (pick < 11)
            req.radio_event = EV_MESSAGE;
        else
            req.radio_event = 3'($urandom_range(EV_TIMEOUT, EV_SPARE));

        req.rx_intact    = ($urandom_range(0, 3) != 0);
        req.reply_wanted = 1'($urandom_range(0, 1));
        req.tx_available = ($urandom_range(0, 3) != 0);
        req.tx_wants_ack = 1'($urandom_range(0, 1));

        pick = $urandom_range(0, 9);
        if (pick < 5)
            req.tx_outcome = TX_OK;
        else if (pick < 8)
            req.tx_outcome = TX_FAIL;
        else if (pick == 8)
            req.tx_outcome = TX_OTHER;
        else
            req.tx_outcome = TX_SPARE;

        if ($urandom_range(0, 7) == 0)
            req.random_extra = 16'($urandom_range(0, 16'hffff));
        else
            req.random_extra = 16'($urandom_range(0, 2 * 32'(cfg_min_listen)));
        return req;
    endfunction

    // ------------------------------------------------------------------
    // stimulus: directed rows, then random phases under each timing plan
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        item_t       req;
        int unsigned n;
        int unsigned plan_idx;

        while (rst_n !== 1'b1) @(posedge clk);

        foreach (stim_rows[k])
        begin
            req.now_ms       = stim_rows[k].now;
            req.radio_event  = stim_rows[k].ev;
            req.rx_intact    = stim_rows[k].intact;
            req.reply_wanted = stim_rows[k].reply;
            req.tx_available = stim_rows[k].avail;
            req.last_sent_ms = stim_rows[k].sent;
            req.tx_outcome   = stim_rows[k].outcome;
            req.tx_wants_ack = stim_rows[k].ack;
            req.random_extra = stim_rows[k].rnd;
            maybe_pause();
            offer_request(req, stim_rows[k].known,
                          result_t'({stim_rows[k].want_mode, stim_rows[k].want_cmd,
                                     stim_rows[k].want_flags}));
        end
        sim_clock_ms = stim_rows[NUM_ROWS-1].now;

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            // reprogram the timing registers between phases, block idle
            if (n != 0 && n % PHASE_LEN == 0)
            begin
                plan_idx = n / PHASE_LEN - 1;
                wait_for_results();
                write_setting(REG_MIN_LISTEN, plans[plan_idx].listen);
                write_setting(REG_MAX_TX, plans[plan_idx].max_tx);
                write_setting(REG_MIN_GAP, plans[plan_idx].gap);
            end
            // long result stall while requests keep coming, so the block
            // fills and drops in_ready
            if (n == 2 * PHASE_LEN + 40)
                hold_off_req = 1'b1;
            // request side goes quiet until everything owed has arrived
            if (n == 3 * PHASE_LEN + 100)
                wait_for_results();
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            maybe_pause();
            offer_request(make_random_request(), 1'b0, '0);
        end

        wait_for_results();
        repeat (8) @(posedge clk);

        $display("%0d requests (%0d directed) over %0d timing settings, %0d results checked",
                 requests_sent, NUM_ROWS, NUM_PLANS + 1, results_checked);
        $display("%0d mismatches, %0d results left pending", mismatches,
                 pending_turns.size());
        if (mismatches == 0 && pending_turns.size() == 0)
            $display("half_duplex_radio_turn_scheduler_unit_test passed");
        else
            $display("half_duplex_radio_turn_scheduler_unit_test failed");
        $finish;
    end

endmodule
